FILE: hdl/pgdt_pkg.sv
// Shared constants, types and helpers for the plane group de-duplication table.
`default_nettype none
package pgdt_pkg;

   // Storage geometry.
   localparam int SLOTS_PER_GROUP = 16;
   localparam int NUM_GROUPS      = 3;
   localparam int NUM_COEFS       = 4;

   // Coefficient and tolerance widths (Q7.16).
   localparam int COEF_WIDTH = 24;
   localparam int TOL_WIDTH  = 23;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(13107);

   // Derived widths.
   localparam int SLOT_W    = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
   localparam int COUNT_W   = $clog2(SLOTS_PER_GROUP + 1);
   localparam int GRP_W     = $clog2(NUM_GROUPS);
   localparam int DEPTH     = NUM_GROUPS * SLOTS_PER_GROUP;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int ENTRY_W   = NUM_COEFS * COEF_WIDTH;
   localparam int CMP_BASE  = (COEF_WIDTH > TOL_WIDTH) ? COEF_WIDTH : TOL_WIDTH;
   localparam int CMP_W     = CMP_BASE + 2;

   // Fixed result field widths.
   localparam int GROUP_OUT_W   = 2;
   localparam int OUTCOME_W     = 2;
   localparam int SLOT_OUT_W    = 4;
   localparam int COUNT_OUT_W   = 5;

   // Axis group codes.
   localparam logic [GRP_W-1:0] GRP_X = GRP_W'(0);
   localparam logic [GRP_W-1:0] GRP_Y = GRP_W'(1);
   localparam logic [GRP_W-1:0] GRP_Z = GRP_W'(2);

   // Outcome codes.
   localparam logic [OUTCOME_W-1:0] OUT_NEW  = OUTCOME_W'(0);
   localparam logic [OUTCOME_W-1:0] OUT_DUP  = OUTCOME_W'(1);
   localparam logic [OUTCOME_W-1:0] OUT_DROP = OUTCOME_W'(2);

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Magnitude of a two's complement coefficient; the most negative value maps
   // to its true magnitude as an unsigned number of the same width.
   function automatic logic [COEF_WIDTH-1:0] coef_mag(input logic [COEF_WIDTH-1:0] v);
      logic [COEF_WIDTH-1:0] r;
      r = v[COEF_WIDTH-1] ? (~v + COEF_WIDTH'(1)) : v;
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/pgdt_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module pgdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/pgdt_match.sv
// Tolerance compare of a candidate plane against one stored plane.
`default_nettype none
module pgdt_match (
   input  wire logic [pgdt_pkg::ENTRY_W-1:0]   cand,
   input  wire logic [pgdt_pkg::ENTRY_W-1:0]   stored,
   input  wire logic [pgdt_pkg::TOL_WIDTH-1:0] tol,
   output      logic                           match
);

   localparam int CW = pgdt_pkg::COEF_WIDTH;
   localparam int DW = pgdt_pkg::CMP_W;

   logic signed [DW-1:0] tol_pos;
   logic signed [DW-1:0] tol_neg;
   logic signed [DW-1:0] diff [pgdt_pkg::NUM_COEFS];
   logic [pgdt_pkg::NUM_COEFS-1:0] close;

   // Each coefficient is close when -tol < diff < tol, which is |diff| < tol.
   always_comb begin
      tol_pos = $signed({{(DW-pgdt_pkg::TOL_WIDTH){1'b0}}, tol});
      tol_neg = -tol_pos;
      for (int i = 0; i < pgdt_pkg::NUM_COEFS; i++) begin
         diff[i] = $signed({{(DW-CW){cand[i*CW+CW-1]}}, cand[i*CW +: CW]})
                 - $signed({{(DW-CW){stored[i*CW+CW-1]}}, stored[i*CW +: CW]});
         close[i] = (diff[i] < tol_pos) && (diff[i] > tol_neg);
      end
      match = &close;
   end

endmodule
`default_nettype wire

FILE: hdl/plane_group_dedup_table.sv
// Top level of the plane group de-duplication table: sequencer, fill counts and plane memory.
// A plane is accepted when start is high and busy is low; busy then stays high while the
// plane's axis group is walked. The stored planes of that group are read one per cycle from
// the single read port of the plane memory. When no duplicate is found, the result strobe
// rises once every plane already held in the group has been read; a duplicate ends the walk
// at the first matching slot, and the strobe rises once that slot's data has been compared.
// The result is presented for exactly one cycle on rsp_strobe and cannot be held off; a new
// plane may be started in that same cycle.
// The merge tolerance is written through csr_wr_en/csr_wr_data and must only change while
// busy is low. No memory clearing pass is needed after reset: per-group fill counts gate
// every read.
`default_nettype none
module plane_group_dedup_table (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Plane input
   input  wire logic                                   start,
   output      logic                                   busy,
   input  wire logic                                   req_start_frame,
   input  wire logic signed [pgdt_pkg::COEF_WIDTH-1:0] req_coef_a,
   input  wire logic signed [pgdt_pkg::COEF_WIDTH-1:0] req_coef_b,
   input  wire logic signed [pgdt_pkg::COEF_WIDTH-1:0] req_coef_c,
   input  wire logic signed [pgdt_pkg::COEF_WIDTH-1:0] req_coef_d,
   // Result output
   output      logic                                   rsp_strobe,
   output      logic [pgdt_pkg::GROUP_OUT_W-1:0]       rsp_axis_group,
   output      logic [pgdt_pkg::OUTCOME_W-1:0]         rsp_outcome,
   output      logic [pgdt_pkg::SLOT_OUT_W-1:0]        rsp_slot_index,
   output      logic [pgdt_pkg::COUNT_OUT_W-1:0]       rsp_group_count,
   // Tolerance register
   input  wire logic                                   csr_wr_en,
   input  wire logic [pgdt_pkg::TOL_WIDTH-1:0]         csr_wr_data
);

   localparam int CW = pgdt_pkg::COEF_WIDTH;
   localparam int NW = pgdt_pkg::COUNT_W;
   localparam int SW = pgdt_pkg::SLOT_W;
   localparam int AW = pgdt_pkg::ADDR_W;
   localparam int GW = pgdt_pkg::GRP_W;

   pgdt_pkg::state_type state_ff, state_in;

   logic [pgdt_pkg::TOL_WIDTH-1:0] tol_ff, tol_in;
   logic [NW-1:0] fill_ff [pgdt_pkg::NUM_GROUPS];
   logic [NW-1:0] fill_in [pgdt_pkg::NUM_GROUPS];

   logic [pgdt_pkg::ENTRY_W-1:0] cand_ff, cand_in;
   logic [GW-1:0]                grp_ff, grp_in;
   logic [NW-1:0]                n_ff, n_in;
   logic [NW-1:0]                k_ff, k_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [SW-1:0]                rd_slot_ff, rd_slot_in;

   logic                                rsp_strobe_ff, rsp_strobe_in;
   logic [pgdt_pkg::GROUP_OUT_W-1:0]    rsp_group_ff, rsp_group_in;
   logic [pgdt_pkg::OUTCOME_W-1:0]      rsp_outcome_ff, rsp_outcome_in;
   logic [pgdt_pkg::SLOT_OUT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [pgdt_pkg::COUNT_OUT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic [CW-1:0] mag_a, mag_b, mag_c;
   logic [GW-1:0] grp_sel;
   logic          accept;

   logic                         mem_wr_en;
   logic                         mem_rd_en;
   logic [AW-1:0]                mem_wr_addr;
   logic [AW-1:0]                mem_rd_addr;
   logic [pgdt_pkg::ENTRY_W-1:0] mem_rd_data;
   logic                         hit;

   // Dominant axis of the incoming plane; ties go to the lower group.
   always_comb begin
      mag_a = pgdt_pkg::coef_mag(req_coef_a);
      mag_b = pgdt_pkg::coef_mag(req_coef_b);
      mag_c = pgdt_pkg::coef_mag(req_coef_c);
      if (mag_a >= mag_b && mag_a >= mag_c) begin
         grp_sel = pgdt_pkg::GRP_X;
      end else if (mag_b >= mag_c) begin
         grp_sel = pgdt_pkg::GRP_Y;
      end else begin
         grp_sel = pgdt_pkg::GRP_Z;
      end
   end

   assign busy   = (state_ff != pgdt_pkg::ST_IDLE);
   assign accept = start && !busy;

   // Memory addresses: group base plus slot.
   assign mem_rd_addr = AW'(grp_ff) * AW'(pgdt_pkg::SLOTS_PER_GROUP) + AW'(k_ff[SW-1:0]);
   assign mem_wr_addr = AW'(grp_ff) * AW'(pgdt_pkg::SLOTS_PER_GROUP) + AW'(n_ff[SW-1:0]);

   // Plane memory.
   pgdt_ram #(
      .WIDTH (pgdt_pkg::ENTRY_W),
      .DEPTH (pgdt_pkg::DEPTH)
   ) u_plane_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (cand_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Compare of the entry read last cycle against the held plane.
   pgdt_match u_match (
      .cand   (cand_ff),
      .stored (mem_rd_data),
      .tol    (tol_ff),
      .match  (hit)
   );

   // Sequencer: capture, walk the group one entry per cycle, then resolve.
   always_comb begin
      state_in       = state_ff;
      tol_in         = csr_wr_en ? csr_wr_data : tol_ff;
      fill_in        = fill_ff;
      cand_in        = cand_ff;
      grp_in         = grp_ff;
      n_in           = n_ff;
      k_in           = k_ff;
      rd_vld_in      = 1'b0;
      rd_slot_in     = rd_slot_ff;
      rsp_strobe_in  = 1'b0;
      rsp_group_in   = rsp_group_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_count_in   = rsp_count_ff;
      mem_wr_en      = 1'b0;
      mem_rd_en      = 1'b0;
      unique case (state_ff)
         pgdt_pkg::ST_IDLE: begin
            if (accept) begin
               cand_in = {req_coef_d, req_coef_c, req_coef_b, req_coef_a};
               grp_in  = grp_sel;
               k_in    = '0;
               if (req_start_frame) begin
                  for (int g = 0; g < pgdt_pkg::NUM_GROUPS; g++) begin
                     fill_in[g] = '0;
                  end
                  n_in = '0;
               end else begin
                  n_in = fill_ff[grp_sel];
               end
               state_in = pgdt_pkg::ST_SCAN;
            end
         end
         pgdt_pkg::ST_SCAN: begin
            rsp_group_in = pgdt_pkg::GROUP_OUT_W'(grp_ff);
            if (rd_vld_ff && hit) begin
               // First matching slot in order.
               rsp_strobe_in  = 1'b1;
               rsp_outcome_in = pgdt_pkg::OUT_DUP;
               rsp_slot_in    = pgdt_pkg::SLOT_OUT_W'(rd_slot_ff);
               rsp_count_in   = pgdt_pkg::COUNT_OUT_W'(n_ff);
               state_in       = pgdt_pkg::ST_IDLE;
            end else if (k_ff < n_ff) begin
               mem_rd_en  = 1'b1;
               rd_vld_in  = 1'b1;
               rd_slot_in = k_ff[SW-1:0];
               k_in       = k_ff + NW'(1);
            end else if (n_ff < NW'(pgdt_pkg::SLOTS_PER_GROUP)) begin
               // No match and room left: append.
               mem_wr_en       = 1'b1;
               fill_in[grp_ff] = n_ff + NW'(1);
               rsp_strobe_in   = 1'b1;
               rsp_outcome_in  = pgdt_pkg::OUT_NEW;
               rsp_slot_in     = pgdt_pkg::SLOT_OUT_W'(n_ff);
               rsp_count_in    = pgdt_pkg::COUNT_OUT_W'(n_ff + NW'(1));
               state_in        = pgdt_pkg::ST_IDLE;
            end else begin
               // No match and the group is full: drop.
               rsp_strobe_in  = 1'b1;
               rsp_outcome_in = pgdt_pkg::OUT_DROP;
               rsp_slot_in    = '0;
               rsp_count_in   = pgdt_pkg::COUNT_OUT_W'(n_ff);
               state_in       = pgdt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pgdt_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pgdt_pkg::ST_IDLE;
         tol_ff        <= pgdt_pkg::TOL_RESET;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int g = 0; g < pgdt_pkg::NUM_GROUPS; g++) begin
            fill_ff[g] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         tol_ff        <= tol_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         fill_ff       <= fill_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cand_ff        <= cand_in;
      grp_ff         <= grp_in;
      n_ff           <= n_in;
      k_ff           <= k_in;
      rd_slot_ff     <= rd_slot_in;
      rsp_group_ff   <= rsp_group_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_axis_group  = rsp_group_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_group_count = rsp_count_ff;

   // An accepted beat always makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an accepted beat");

   // A result beat only follows a cycle spent walking a group.
   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == pgdt_pkg::ST_SCAN))
      else $error("result beat without a preceding scan");

   // A read in flight is always for a slot below the group's fill count.
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (NW'(rd_slot_ff) < n_ff))
      else $error("read of a slot beyond the fill count");

   // The fill count of the group being walked never exceeds its capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pgdt_pkg::ST_SCAN) |->
         (fill_ff[grp_ff] <= NW'(pgdt_pkg::SLOTS_PER_GROUP)))
      else $error("group fill count above capacity");

endmodule
`default_nettype wire
